// ===== hw/rtl/bba_pkg.sv =====
package bba_pkg;

	localparam int TOP_BLOCKS = 32;
	localparam int TOP_ORDER  = 10;
	localparam int UNIT_BYTES = 128;
	localparam int POOL_UNITS = TOP_BLOCKS << TOP_ORDER;
	localparam int UW         = 15;
	localparam int BM_WORDS   = POOL_UNITS / 64;
	localparam int BW         = 9;
	localparam int HW         = 6;
	localparam int OW         = 4;
	localparam int CW         = 16;
	localparam int NEED_W     = 19;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_ZERO     = 3'd1,
		ST_TOO_BIG  = 3'd2,
		ST_NO_FREE  = 3'd3,
		ST_BAD_FREE = 3'd4
	} status_t;

endpackage

// ===== hw/rtl/bba_ram.sv =====
module bba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ===== hw/rtl/buddy_block_allocator_core.sv =====
// Allocate: after the item is taken, the size checks, then a scan of the free bitmap that reads
// each word (S_SCR, S_SCD, S_SCB), 512 words per order searched, plus a header read per set bit
// inspected, then a header and bitmap write per block written by the split; the result is registered.
// Free: the header is read and checked, each merge level reads the buddy header and clears both
// blocks, the final block is written, then the result is registered. One item at a time.
// Reset (arst_n low) clears control state; a clearing pass over every unit then rebuilds the pool.
module buddy_block_allocator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // request_size[17:0], block_offset[32:18], zero pad
	input  logic        s_axis_tuser,  // action: 0 allocate, 1 free
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,  // status, granted_offset, granted_order,
	                                   // block_count, free_count, zero pad
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata
);
	import bba_pkg::*;

	// One-hot sequencer. BLK_H and BLK_W form a shared subroutine that writes one
	// block header and updates its bit in the free bitmap, then returns to sb_ret_q.
	typedef enum logic [17:0] {
		S_INIT   = 18'h00001,
		S_IDLE   = 18'h00002,
		S_ACHK   = 18'h00004,
		S_SCR    = 18'h00008,
		S_SCD    = 18'h00010,
		S_SCB    = 18'h00020,
		S_SCH    = 18'h00040,
		S_SPLIT  = 18'h00080,
		S_FRD    = 18'h00100,
		S_FCHK   = 18'h00200,
		S_FMRG   = 18'h00400,
		S_FMCMP  = 18'h00800,
		S_FCLO   = 18'h01000,
		S_FMV    = 18'h02000,
		S_FFIN   = 18'h04000,
		S_BLKH   = 18'h08000,
		S_BLKW   = 18'h10000,
		S_DONE   = 18'h20000
	} state_t;

	state_t           st_q, sb_ret_q;
	logic [UW-1:0]    clr_q;
	logic [6:0]       hdr_bytes_q;
	logic [17:0]      size_q;
	logic [UW-1:0]    off_q, u_q, bud_q, sb_u_q;
	logic [HW-1:0]    sb_h_q;
	logic [OW-1:0]    want_q, ord_q;
	logic [BW-1:0]    w_q;
	logic [63:0]      bits_q;
	logic [CW-1:0]    blk_cnt_q, free_cnt_q;
	status_t          res_st_q;
	logic [UW-1:0]    res_off_q;
	logic [OW-1:0]    res_ord_q;
	logic             m_valid_q;
	logic [55:0]      m_data_q;

	// Memory ports.
	logic             h_we, h_re, b_we, b_re;
	logic [UW-1:0]    h_waddr, h_raddr;
	logic [HW-1:0]    h_wdata, h_rdata;
	logic [BW-1:0]    b_waddr, b_raddr;
	logic [63:0]      b_wdata, b_rdata;

	// Request sizing: bytes needed and the smallest order that holds them.
	logic [NEED_W-1:0] needed;
	logic [OW-1:0]     want;
	logic              big;
	always_comb begin
		needed = NEED_W'(size_q) + NEED_W'(hdr_bytes_q);
		big    = needed >= NEED_W'(UNIT_BYTES << TOP_ORDER);
		want   = '0;
		for (int i = 0; i < TOP_ORDER; i++) begin
			if (needed > NEED_W'(UNIT_BYTES << i)) want = want + OW'(1);
		end
	end

	// Lowest set bit of the bitmap word under inspection.
	logic [5:0] low_b;
	always_comb begin
		low_b = '0;
		for (int i = 63; i >= 0; i--) begin
			if (bits_q[i]) low_b = 6'(i);
		end
	end

	logic [UW-1:0] bud;
	logic [OW-1:0] ord_dn;
	logic [63:0]   bit_m;
	assign bud    = off_q ^ (UW'(1) << ord_q);
	assign ord_dn = ord_q - OW'(1);
	assign bit_m  = 64'(1) << sb_u_q[5:0];

	always_comb begin
		h_we    = 1'b0;
		h_waddr = sb_u_q;
		h_wdata = sb_h_q;
		h_re    = 1'b0;
		h_raddr = off_q;
		b_we    = 1'b0;
		b_waddr = sb_u_q[UW-1:6];
		b_wdata = (b_rdata & ~bit_m) | (sb_h_q[1] ? bit_m : 64'h0);
		b_re    = 1'b0;
		b_raddr = w_q;
		unique case (st_q)
			S_INIT: begin
				h_we    = 1'b1;
				h_waddr = clr_q;
				h_wdata = (clr_q[TOP_ORDER-1:0] == '0) ?
				          {OW'(TOP_ORDER), 2'b11} : '0;
				b_we    = (clr_q[UW-1:BW] == '0);
				b_waddr = clr_q[BW-1:0];
				b_wdata = (clr_q[TOP_ORDER-7:0] == '0) ? 64'h1 : 64'h0;
			end
			S_SCR:  b_re = 1'b1;
			S_SCB: begin
				h_re    = (bits_q != '0);
				h_raddr = {w_q, low_b};
			end
			S_FRD:  h_re = 1'b1;
			S_FMRG: begin
				h_re    = 1'b1;
				h_raddr = bud;
			end
			S_BLKH: begin
				h_we    = 1'b1;
				b_re    = 1'b1;
				b_raddr = sb_u_q[UW-1:6];
			end
			S_BLKW: b_we = 1'b1;
			default: ;
		endcase
	end

	bba_ram #(.WIDTH(HW), .DEPTH(POOL_UNITS)) u_hdr_ram (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.re(h_re), .raddr(h_raddr), .rdata(h_rdata)
	);

	bba_ram #(.WIDTH(64), .DEPTH(BM_WORDS)) u_bm_ram (
		.clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
		.re(b_re), .raddr(b_raddr), .rdata(b_rdata)
	);

	assign s_axis_tready = (st_q == S_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_INIT;
			sb_ret_q    <= S_IDLE;
			clr_q       <= '0;
			hdr_bytes_q <= 7'd40;
			blk_cnt_q   <= CW'(TOP_BLOCKS);
			free_cnt_q  <= CW'(TOP_BLOCKS);
			m_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) hdr_bytes_q <= cfg_wdata;
			if (m_valid_q && m_axis_tready) m_valid_q <= 1'b0;
			unique case (st_q)
				S_INIT: begin
					clr_q <= clr_q + UW'(1);
					if (clr_q == UW'(POOL_UNITS - 1)) st_q <= S_IDLE;
				end
				S_IDLE: begin
					if (s_axis_tvalid) begin
						size_q   <= s_axis_tdata[17:0];
						off_q    <= s_axis_tdata[32:18];
						res_off_q <= '0;
						res_ord_q <= '0;
						st_q     <= s_axis_tuser ? S_FRD : S_ACHK;
					end
				end
				S_ACHK: begin
					if (size_q == '0) begin
						res_st_q <= ST_ZERO;
						st_q     <= S_DONE;
					end else if (big) begin
						res_st_q <= ST_TOO_BIG;
						st_q     <= S_DONE;
					end else begin
						want_q <= want;
						ord_q  <= want;
						w_q    <= '0;
						st_q   <= S_SCR;
					end
				end
				S_SCR: st_q <= S_SCD;
				S_SCD: begin
					bits_q <= b_rdata;
					st_q   <= S_SCB;
				end
				S_SCB: begin
					if (bits_q == '0) begin
						w_q <= w_q + BW'(1);
						if (w_q == BW'(BM_WORDS - 1)) begin
							if (ord_q == OW'(TOP_ORDER)) begin
								res_st_q <= ST_NO_FREE;
								st_q     <= S_DONE;
							end else begin
								ord_q <= ord_q + OW'(1);
								st_q  <= S_SCR;
							end
						end else begin
							st_q <= S_SCR;
						end
					end else begin
						u_q            <= {w_q, low_b};
						bits_q[low_b]  <= 1'b0;
						st_q           <= S_SCH;
					end
				end
				S_SCH: begin
					if (h_rdata[HW-1:2] == ord_q) begin
						free_cnt_q <= free_cnt_q - CW'(1);
						st_q       <= S_SPLIT;
					end else begin
						st_q <= S_SCB;
					end
				end
				S_SPLIT: begin
					st_q <= S_BLKH;
					if (ord_q > want_q) begin
						// Free the upper half and keep splitting the lower one.
						ord_q      <= ord_dn;
						sb_u_q     <= u_q + (UW'(1) << ord_dn);
						sb_h_q     <= {ord_dn, 2'b11};
						sb_ret_q   <= S_SPLIT;
						blk_cnt_q  <= blk_cnt_q + CW'(1);
						free_cnt_q <= free_cnt_q + CW'(1);
					end else begin
						sb_u_q    <= u_q;
						sb_h_q    <= {want_q, 2'b01};
						sb_ret_q  <= S_DONE;
						res_st_q  <= ST_OK;
						res_off_q <= u_q;
						res_ord_q <= want_q;
					end
				end
				S_FRD: st_q <= S_FCHK;
				S_FCHK: begin
					if (!h_rdata[0] || h_rdata[1]) begin
						res_st_q <= ST_BAD_FREE;
						st_q     <= S_DONE;
					end else begin
						ord_q <= h_rdata[HW-1:2];
						st_q  <= S_FMRG;
					end
				end
				S_FMRG: begin
					bud_q <= bud;
					st_q  <= (ord_q >= OW'(TOP_ORDER)) ? S_FFIN : S_FMCMP;
				end
				S_FMCMP: begin
					if (h_rdata == {ord_q, 2'b11}) begin
						sb_u_q   <= bud_q;
						sb_h_q   <= '0;
						sb_ret_q <= S_FCLO;
						st_q     <= S_BLKH;
					end else begin
						st_q <= S_FFIN;
					end
				end
				S_FCLO: begin
					sb_u_q   <= off_q;
					sb_h_q   <= '0;
					sb_ret_q <= S_FMV;
					st_q     <= S_BLKH;
				end
				S_FMV: begin
					if (bud_q < off_q) off_q <= bud_q;
					ord_q      <= ord_q + OW'(1);
					blk_cnt_q  <= blk_cnt_q - CW'(1);
					free_cnt_q <= free_cnt_q - CW'(1);
					st_q       <= S_FMRG;
				end
				S_FFIN: begin
					free_cnt_q <= free_cnt_q + CW'(1);
					res_st_q   <= ST_OK;
					res_off_q  <= off_q;
					res_ord_q  <= ord_q;
					sb_u_q     <= off_q;
					sb_h_q     <= {ord_q, 2'b11};
					sb_ret_q   <= S_DONE;
					st_q       <= S_BLKH;
				end
				S_BLKH: st_q <= S_BLKW;
				S_BLKW: st_q <= sb_ret_q;
				S_DONE: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						m_data_q  <= {2'b00, free_cnt_q, blk_cnt_q, res_ord_q, res_off_q,
						              res_st_q};
						st_q      <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_free_le_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		free_cnt_q <= blk_cnt_q) else $error("free count exceeds block count");
	a_blocks_range: assert property (@(posedge clk) disable iff (!arst_n)
		blk_cnt_q >= CW'(TOP_BLOCKS) && blk_cnt_q <= CW'(POOL_UNITS))
		else $error("block count out of range");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && m_data_q[2:0] != ST_OK |-> m_data_q[21:3] == '0)
		else $error("failed status with nonzero grant");
	a_sub_return: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_BLKH |=> st_q == S_BLKW) else $error("block write interrupted");
`endif
endmodule

// ===== dv/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bba_pkg::*;

	// Cycles with no item moving on either side before the run is declared hung.
	// The slowest allocate scans eleven orders of 512 bitmap words plus set bits.
	// The reset clearing pass visits every unit, and the long receiver hold stalls
	// the output. The limit covers all of these several times over.
	localparam int STALL_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;
	logic        cfg_we = 1'b0;
	logic [6:0]  cfg_wdata = '0;

	buddy_block_allocator_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	typedef enum bit {ACT_ALLOC = 1'b0, ACT_FREE = 1'b1} action_t;

	typedef struct {
		status_t     status;
		bit [14:0]   offset;
		bit [3:0]    order;
		bit [15:0]   blocks;
		bit [15:0]   frees;
	} grant_t;

	// Shadow of the allocator. Each unit header holds start in bit 0, free in
	// bit 1 and the order above them. Free block starts are kept per order in
	// sorted sets so that the lowest free address of an order is found quickly.
	bit [5:0] unit_hdr [POOL_UNITS];
	bit       free_at [TOP_ORDER+1][int];
	int       blocks_now;
	int       frees_now;
	int       hdr_bytes;

	grant_t   grants_due[$];
	int       live_blocks[$];
	int       last_freed = 0;

	int       src_idle_pct = 0;
	int       snk_idle_pct = 0;
	int       hold_req = 0;
	int       hold_ack = 0;
	int       hold_left = 0;
	int       stall_cycles = 0;
	int       errors = 0;
	int       items_sent = 0;
	int       grants_seen = 0;
	int       n_ok = 0, n_exhausted = 0, n_bad_free = 0, n_cfg = 0;

	function automatic void mark_block(int u, int o, bit is_free);
		if (unit_hdr[u][1])
			free_at[unit_hdr[u][5:2]].delete(u);
		unit_hdr[u] = {o[3:0], is_free, 1'b1};
		if (is_free)
			free_at[o][u] = 1'b1;
	endfunction

	function automatic void unmark_block(int u);
		if (unit_hdr[u][1])
			free_at[unit_hdr[u][5:2]].delete(u);
		unit_hdr[u] = '0;
	endfunction

	function automatic void reset_shadow();
		for (int u = 0; u < POOL_UNITS; u++)
			unit_hdr[u] = '0;
		for (int o = 0; o <= TOP_ORDER; o++)
			free_at[o].delete();
		for (int t = 0; t < TOP_BLOCKS; t++)
			mark_block(t << TOP_ORDER, TOP_ORDER, 1'b1);
		blocks_now = TOP_BLOCKS;
		frees_now = TOP_BLOCKS;
		hdr_bytes = 40;
	endfunction

	// Works out the grant for one accepted item and updates the shadow state.
	function automatic grant_t buddy_grant(action_t act, int size, int off);
		grant_t g;
		int needed, want, o, u, bud;
		bit found;
		g = '{ST_OK, 0, 0, 0, 0};
		if (act == ACT_ALLOC) begin
			needed = size + hdr_bytes;
			if (size == 0) begin
				g.status = ST_ZERO;
			end else if (needed >= (UNIT_BYTES << TOP_ORDER)) begin
				g.status = ST_TOO_BIG;
			end else begin
				want = 0;
				while (want < TOP_ORDER && needed > (UNIT_BYTES << want))
					want++;
				found = 0;
				for (o = want; o <= TOP_ORDER; o++) begin
					if (free_at[o].first(u)) begin
						found = 1;
						break;
					end
				end
				if (!found) begin
					g.status = ST_NO_FREE;
				end else begin
					frees_now--;
					// Halve down to the wanted order, freeing each upper half.
					while (o > want) begin
						o--;
						mark_block(u + (1 << o), o, 1'b1);
						blocks_now++;
						frees_now++;
					end
					mark_block(u, want, 1'b0);
					g.offset = 15'(u);
					g.order = 4'(want);
				end
			end
		end else begin
			if (!unit_hdr[off][0] || unit_hdr[off][1]) begin
				g.status = ST_BAD_FREE;
			end else begin
				o = int'(unit_hdr[off][5:2]);
				// Merge upward while the equal-order buddy is free.
				while (o < TOP_ORDER) begin
					bud = off ^ (1 << o);
					if (bud >= POOL_UNITS || unit_hdr[bud] != {o[3:0], 2'b11})
						break;
					unmark_block(bud);
					unmark_block(off);
					if (bud < off)
						off = bud;
					o++;
					blocks_now--;
					frees_now--;
				end
				mark_block(off, o, 1'b1);
				frees_now++;
				g.offset = 15'(off);
				g.order = 4'(o);
			end
		end
		g.blocks = 16'(blocks_now);
		g.frees = 16'(frees_now);
		return g;
	endfunction

	// Offers one item and waits until it is taken, then records its grant.
	task automatic send_item(action_t act, int size, int off);
		grant_t g;
		s_axis_tuser <= act;
		s_axis_tdata <= {7'd0, off[14:0], size[17:0]};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		g = buddy_grant(act, size, off);
		grants_due.push_back(g);
		items_sent++;
		if (g.status == ST_OK && act == ACT_ALLOC)
			live_blocks.push_back(g.offset);
		if (g.status == ST_OK) n_ok++;
		if (g.status == ST_NO_FREE) n_exhausted++;
		if (g.status == ST_BAD_FREE) n_bad_free++;
		if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic free_live(int idx);
		int off;
		off = live_blocks[idx];
		live_blocks.delete(idx);
		last_freed = off;
		send_item(ACT_FREE, 0, off);
	endtask

	// Drops valid and waits until every grant is in; a result is sent only after its
	// writes, so the allocator is then idle. It keeps waiting before anything else happens.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (grants_due.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_header_bytes(int value);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= value[6:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		hdr_bytes = value;
		n_cfg++;
	endtask

	// Receiver: random stalls, plus a long hold-off when one is requested.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_req != hold_ack) begin
			hold_ack = hold_req;
			hold_left = HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// Result checker: each grant taken is compared with the oldest one due.
	always @(posedge clk) begin
		grant_t g;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			grants_seen++;
			if (grants_due.size() == 0) begin
				$error("grant with none due: tdata=%h", m_axis_tdata);
				errors++;
			end else begin
				g = grants_due.pop_front();
				if (m_axis_tdata[2:0] != g.status) begin
					$error("status: expected %0d, actual %0d", g.status, m_axis_tdata[2:0]);
					errors++;
				end
				if (m_axis_tdata[17:3] != g.offset) begin
					$error("granted_offset: expected %0d, actual %0d",
						g.offset, m_axis_tdata[17:3]);
					errors++;
				end
				if (m_axis_tdata[21:18] != g.order) begin
					$error("granted_order: expected %0d, actual %0d",
						g.order, m_axis_tdata[21:18]);
					errors++;
				end
				if (m_axis_tdata[37:22] != g.blocks) begin
					$error("block_count: expected %0d, actual %0d",
						g.blocks, m_axis_tdata[37:22]);
					errors++;
				end
				if (m_axis_tdata[53:38] != g.frees) begin
					$error("free_count: expected %0d, actual %0d",
						g.frees, m_axis_tdata[53:38]);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles where no item moves on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("buddy_block_allocator_core verification failed");
				$finish;
			end
		end
	end

	// Size edges, one block of every order, merges back to the top order and
	// the ways a free can be refused.
	task automatic test_directed();
		send_item(ACT_ALLOC, 0, 0);
		send_item(ACT_ALLOC, 262143, 32767);
		send_item(ACT_ALLOC, 131032, 0);
		send_item(ACT_ALLOC, 131031, 0);
		send_item(ACT_ALLOC, 1, 0);
		for (int o = 1; o <= TOP_ORDER; o++)
			send_item(ACT_ALLOC, (UNIT_BYTES << o) - 40, 0);
		send_item(ACT_FREE, 0, 1);
		send_item(ACT_FREE, 0, 32767);
		while (live_blocks.size() != 0)
			free_live(live_blocks.size() - 1);
		send_item(ACT_FREE, 0, last_freed);
		send_item(ACT_FREE, 0, 0);
	endtask

	// Takes every top block, asks for one more and for a small block, then gives them all back.
	task automatic test_exhaustion();
		for (int i = 0; i <= TOP_BLOCKS; i++)
			send_item(ACT_ALLOC, 100000, 0);
		send_item(ACT_ALLOC, 1, 0);
		while (live_blocks.size() != 0)
			free_live($urandom_range(live_blocks.size() - 1));
	endtask

	task automatic random_item();
		int r;
		r = $urandom_range(99);
		if (live_blocks.size() > 150)
			r = 99;
		if (r < 30)
			send_item(ACT_ALLOC, $urandom_range(1, 300), $urandom_range(32767));
		else if (r < 44)
			send_item(ACT_ALLOC, $urandom_range(1, 5000), $urandom_range(32767));
		else if (r < 50)
			send_item(ACT_ALLOC, $urandom_range(1, 131071), $urandom_range(32767));
		else if (r < 52)
			send_item(ACT_ALLOC, 0, $urandom_range(32767));
		else if (r < 54)
			send_item(ACT_ALLOC, $urandom_range(131000, 262143), $urandom_range(32767));
		else if (r < 58)
			send_item(ACT_FREE, $urandom_range(262143), $urandom_range(32767));
		else if (r < 61)
			send_item(ACT_FREE, $urandom_range(262143), last_freed);
		else if (live_blocks.size() != 0)
			free_live($urandom_range(live_blocks.size() - 1));
		else
			send_item(ACT_ALLOC, $urandom_range(1, 300), 0);
	endtask

	task automatic test_random(int n, int src_pct, int snk_pct);
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		repeat (n) random_item();
	endtask

	// Receiver holds off while the sender keeps offering cheap frees.
	task automatic test_backpressure();
		src_idle_pct = 0;
		snk_idle_pct = 0;
		repeat (30) send_item(ACT_ALLOC, $urandom_range(1, 200), 0);
		drain();
		hold_req++;
		while (live_blocks.size() != 0)
			free_live(0);
		repeat (10) send_item(ACT_FREE, 0, $urandom_range(32767));
	endtask

	initial begin
		reset_shadow();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		write_header_bytes(0);
		test_directed();
		write_header_bytes(127);
		test_exhaustion();
		test_random(320, 29, 47);
		write_header_bytes($urandom_range(1, 126));
		test_random(320, 47, 29);
		write_header_bytes(40);
		test_random(320, 0, 0);
		test_backpressure();

		drain();
		$display("Sent %0d items, checked %0d grants over %0d header settings.",
			items_sent, grants_seen, n_cfg + 1);
		$display("Ok %0d, pool exhausted %0d, refused frees %0d.",
			n_ok, n_exhausted, n_bad_free);
		if (errors == 0)
			$display("buddy_block_allocator_core verification clean");
		else
			$display("buddy_block_allocator_core verification failed");
		$finish;
	end
endmodule
